// File: hw/rtl/uart_rx_fifo_register_block_top_macros.svh
// Assertion macros for the UART register block.
`ifndef UART_RX_FIFO_REGISTER_BLOCK_TOP_MACROS_SVH
`define UART_RX_FIFO_REGISTER_BLOCK_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, suspended while reset is asserted.
`define URX_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define URX_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define URX_ASSERT(name, clk, rstn, prop, msg)
`define URX_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// File: hw/rtl/uartrx_pkg.sv
// Types and constants for the UART register block.
`timescale 1ns / 1ps
`default_nettype none

package uartrx_pkg;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int RX_FREE_W = 5;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_PUSH  = 2'd2
    } kind_t;

    localparam logic [3:0] REG_LINE_CTL   = 4'd0;
    localparam logic [3:0] REG_CTL        = 4'd1;
    localparam logic [3:0] REG_FIFO_CTL   = 4'd2;
    localparam logic [3:0] REG_MODEM_CTL  = 4'd3;
    localparam logic [3:0] REG_STATUS     = 4'd4;
    localparam logic [3:0] REG_ERR        = 4'd5;
    localparam logic [3:0] REG_FIFO_STAT  = 4'd6;
    localparam logic [3:0] REG_MODEM_STAT = 4'd7;
    localparam logic [3:0] REG_TX         = 4'd8;
    localparam logic [3:0] REG_RX         = 4'd9;
    localparam logic [3:0] REG_BAUD       = 4'd10;

    // status register bits
    localparam int ST_RX_READY_BIT = 0;
    localparam int ST_TX_BUF_EMPTY_BIT = 1;
    localparam int ST_TX_EMPTY_BIT = 2;
    localparam int ST_RX_INT_BIT = 4;
    // fifo status full flag
    localparam int FS_RX_FULL_BIT = 8;
    // receive interrupt enable in the control register (latch bit shifted by 8)
    localparam int CTL_RX_INT_EN_BIT = 12;

endpackage

`default_nettype wire

// File: hw/rtl/uart_rx_fifo_register_block_top.sv
// Top level of the UART register block with its receive ring.
`timescale 1ns / 1ps
`default_nettype none

`include "uart_rx_fifo_register_block_top_macros.svh"

// UART register block. Each item on the s_ side is a bus read, a bus write or a
// received byte offered by the host; each gives exactly one result item on the
// m_ side. The block takes one item per clock while the result register is free
// or m_tready is high: an item waits in the input register, is decoded against
// the registers and the receive ring in a single pass, and lands in the result
// register. A result still waiting on m_tready holds the item in the input
// register and so blocks the next item. The receive ring holds RX_DEPTH bytes in
// flops and needs no clearing after reset. irq_enable is written through cfg_*;
// the user must do so only while idle, which the block does not enforce.
module uart_rx_fifo_register_block_top
    import uartrx_pkg::*;
#(
    parameter int RX_DEPTH = 16
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    // reg_sel[3:0], write_data[35:4], rx_byte[43:36], zero[47:44]
    input  wire [S_TDATA_W-1:0]   s_tdata,
    // kind[1:0]
    input  wire [S_TUSER_W-1:0]   s_tuser,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    // read_data[31:0], push_accepted[32], rx_free[37:33], irq_line[38],
    // tx_valid[39], tx_byte[47:40]
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire                   cfg_data
);

    localparam int PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CNT_W = $clog2(RX_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RX_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RX_DEPTH - 1);

    // input register
    logic             in_valid_reg;
    logic [1:0]       in_kind_reg;
    logic [3:0]       in_sel_reg;
    logic [31:0]      in_wdata_reg;
    logic [7:0]       in_rxb_reg;

    // result register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    // block state
    logic [7:0]       ring_reg [RX_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      line_ctl_reg, line_ctl_next;
    logic [31:0]      ctl_reg, ctl_next;
    logic [31:0]      fifo_ctl_reg, fifo_ctl_next;
    logic [31:0]      modem_ctl_reg, modem_ctl_next;
    logic [31:0]      baud_reg, baud_next;
    logic             latch_reg, latch_next;
    logic             irq_en_reg;

    logic             advance;
    logic             ring_we;
    logic [PTR_W-1:0] tail;
    logic [SUM_W-1:0] tail_sum;
    logic [31:0]      rd;
    logic             acc;
    logic             txv;
    logic [7:0]       txb;
    logic             irq;
    logic [RX_FREE_W-1:0] rx_free;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail = (tail_sum >= SUM_W'(RX_DEPTH)) ? PTR_W'(tail_sum - SUM_W'(RX_DEPTH))
                                                 : PTR_W'(tail_sum);

    always_comb begin
        rd             = 32'd0;
        acc            = 1'b0;
        txv            = 1'b0;
        txb            = 8'd0;
        ring_we        = 1'b0;
        head_next      = head_reg;
        count_next     = count_reg;
        line_ctl_next  = line_ctl_reg;
        ctl_next       = ctl_reg;
        fifo_ctl_next  = fifo_ctl_reg;
        modem_ctl_next = modem_ctl_reg;
        baud_next      = baud_reg;
        latch_next     = latch_reg;
        case (in_kind_reg)
            KIND_READ: begin
                case (in_sel_reg)
                    REG_LINE_CTL:  rd = line_ctl_reg;
                    REG_CTL:       rd = ctl_reg;
                    REG_FIFO_CTL:  rd = fifo_ctl_reg;
                    REG_MODEM_CTL: rd = modem_ctl_reg;
                    REG_STATUS: begin
                        rd[ST_TX_EMPTY_BIT]     = 1'b1;
                        rd[ST_TX_BUF_EMPTY_BIT] = 1'b1;
                        rd[ST_RX_READY_BIT]     = (count_reg != '0);
                        rd[ST_RX_INT_BIT]       = latch_reg;
                    end
                    REG_FIFO_STAT: begin
                        rd[3:0]            = 4'(count_reg);
                        rd[FS_RX_FULL_BIT] = (count_reg == DEPTH_C);
                    end
                    REG_RX: begin
                        if (count_reg != '0) begin
                            rd         = {24'd0, ring_reg[head_reg]};
                            head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    REG_BAUD:      rd = baud_reg;
                    default:       rd = 32'd0;
                endcase
            end
            KIND_WRITE: begin
                case (in_sel_reg)
                    REG_LINE_CTL:  line_ctl_next = in_wdata_reg;
                    REG_CTL:       ctl_next = in_wdata_reg;
                    REG_FIFO_CTL:  fifo_ctl_next = in_wdata_reg;
                    REG_MODEM_CTL: modem_ctl_next = in_wdata_reg;
                    REG_STATUS: begin
                        if (in_wdata_reg[ST_RX_INT_BIT]) begin
                            latch_next = 1'b0;
                        end
                    end
                    REG_TX: begin
                        txv = 1'b1;
                        txb = in_wdata_reg[7:0];
                    end
                    REG_BAUD:      baud_next = in_wdata_reg;
                    default: ;
                endcase
            end
            KIND_PUSH: begin
                if (count_reg != DEPTH_C) begin
                    ring_we    = 1'b1;
                    count_next = count_reg + 1'b1;
                    latch_next = 1'b1;
                    acc        = 1'b1;
                end
            end
            default: ;
        endcase
        rx_free = RX_FREE_W'(DEPTH_C - count_next);
        irq     = latch_next && ctl_next[CTL_RX_INT_EN_BIT] && irq_en_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            line_ctl_reg  <= 32'd0;
            ctl_reg       <= 32'd0;
            fifo_ctl_reg  <= 32'd0;
            modem_ctl_reg <= 32'd0;
            baud_reg      <= 32'd0;
            latch_reg     <= 1'b0;
            irq_en_reg    <= 1'b1;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                line_ctl_reg  <= line_ctl_next;
                ctl_reg       <= ctl_next;
                fifo_ctl_reg  <= fifo_ctl_next;
                modem_ctl_reg <= modem_ctl_next;
                baud_reg      <= baud_next;
                latch_reg     <= latch_next;
            end
            if (cfg_valid && cfg_ready) begin
                irq_en_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg  <= s_tuser[1:0];
            in_sel_reg   <= s_tdata[3:0];
            in_wdata_reg <= s_tdata[35:4];
            in_rxb_reg   <= s_tdata[43:36];
        end
        if (advance) begin
            out_data_reg <= {txb, txv, irq, rx_free, acc, rd};
        end
        if (advance && ring_we) begin
            ring_reg[tail] <= in_rxb_reg;
        end
    end

    `URX_ASSERT(a_count_in_range, aclk, aresetn, count_reg <= DEPTH_C, "ring count beyond depth")
    `URX_ASSERT(a_push_counts, aclk, aresetn, (advance && acc) |=> (count_reg == $past(count_reg) + 1'b1), "accepted push did not bump count")
    `URX_ASSERT(a_push_latches, aclk, aresetn, (advance && acc) |=> latch_reg, "accepted push did not set latch")
    `URX_ASSERT(a_free_matches, aclk, aresetn, ($past(aresetn) && $past(advance)) |-> (out_data_reg[37:33] == RX_FREE_W'(DEPTH_C - count_reg)), "rx_free disagrees with ring count")
    `URX_ASSERT_ALWAYS(a_reset_idle, aclk, !$past(aresetn) |-> (!in_valid_reg && !out_valid_reg && count_reg == '0), "block not idle after reset")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the UART register block and its receive ring.
`timescale 1ns / 1ps

module testbench;
    import uartrx_pkg::*;

    localparam int         RING_DEPTH = 16;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [3:0] REG_UNMAPPED = 4'd15;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] read_data;
        logic        push_ok;
        logic [4:0]  rx_free;
        logic        irq_line;
        logic        tx_valid;
        logic [7:0]  tx_byte;
    } uart_res_t;

    typedef struct {
        logic [1:0]  kind;
        logic [3:0]  sel;
        logic [31:0] wdata;
        logic [7:0]  rbyte;
        int          reps;
        bit          fixed;
        uart_res_t   res;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // reg_sel[3:0], write_data[35:4], rx_byte[43:36]
    logic [S_TUSER_W-1:0] s_tuser;   // kind[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // read_data, push_accepted, rx_free, irq, tx_valid, tx_byte
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;

    // predictor state
    logic [7:0]  ring_mem [RING_DEPTH];
    logic [3:0]  ring_head;
    logic [4:0]  ring_count;
    logic [31:0] line_ctl, uart_ctl, fifo_ctl, modem_ctl, baud_div;
    logic        rx_latch;
    logic        irq_en;

    uart_res_t pending_results [$];
    stim_row_t dir_rows [$];

    bit jitter_on;
    int sink_hold_req;
    int err_count, items_sent, results_checked, refused_pushes, tx_bytes, irq_high;
    int input_stalls, cfg_writes, directed_items;

    uart_rx_fifo_register_block_top #(
        .RX_DEPTH(RING_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic uart_res_t uart_regs_step(input logic [1:0] kind, input logic [3:0] sel,
                                                 input logic [31:0] wd, input logic [7:0] rb);
        uart_res_t  r;
        logic [3:0] slot;
        r = '0;
        if (kind == KIND_READ) begin
            case (sel)
                REG_LINE_CTL:  r.read_data = line_ctl;
                REG_CTL:       r.read_data = uart_ctl;
                REG_FIFO_CTL:  r.read_data = fifo_ctl;
                REG_MODEM_CTL: r.read_data = modem_ctl;
                REG_BAUD:      r.read_data = baud_div;
                REG_STATUS: begin
                    r.read_data[ST_TX_EMPTY_BIT]     = 1'b1;
                    r.read_data[ST_TX_BUF_EMPTY_BIT] = 1'b1;
                    r.read_data[ST_RX_READY_BIT]     = (ring_count != 0);
                    r.read_data[ST_RX_INT_BIT]       = rx_latch;
                end
                REG_FIFO_STAT: begin
                    r.read_data[3:0]            = ring_count[3:0];
                    r.read_data[FS_RX_FULL_BIT] = (ring_count >= RING_DEPTH);
                end
                REG_RX: begin
                    if (ring_count != 0) begin
                        r.read_data[7:0] = ring_mem[ring_head];
                        ring_head  = ring_head + 4'd1;
                        ring_count = ring_count - 5'd1;
                    end
                end
                default: ;
            endcase
        end else if (kind == KIND_WRITE) begin
            case (sel)
                REG_LINE_CTL:  line_ctl  = wd;
                REG_CTL:       uart_ctl  = wd;
                REG_FIFO_CTL:  fifo_ctl  = wd;
                REG_MODEM_CTL: modem_ctl = wd;
                REG_BAUD:      baud_div  = wd;
                REG_STATUS: begin
                    if (wd[ST_RX_INT_BIT]) rx_latch = 1'b0;
                end
                REG_TX: begin
                    r.tx_valid = 1'b1;
                    r.tx_byte  = wd[7:0];
                end
                default: ;
            endcase
        end else if (kind == KIND_PUSH) begin
            if (ring_count < RING_DEPTH) begin
                slot = ring_head + ring_count[3:0];
                ring_mem[slot] = rb;
                ring_count = ring_count + 5'd1;
                rx_latch = 1'b1;
                r.push_ok = 1'b1;
            end
        end
        r.rx_free  = 5'(RING_DEPTH) - ring_count;
        r.irq_line = rx_latch & uart_ctl[CTL_RX_INT_EN_BIT] & irq_en;
        return r;
    endfunction

    task automatic offer_item(input logic [1:0] kind, input logic [3:0] sel,
                              input logic [31:0] wd, input logic [7:0] rb,
                              input bit fixed, input uart_res_t lit);
        uart_res_t predicted;
        while (jitter_on && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, rb, wd, sel};
        @(posedge aclk);
        while (!s_tready) begin
            input_stalls++;
            @(posedge aclk);
        end
        predicted = uart_regs_step(kind, sel, wd, rb);
        pending_results.push_back(fixed ? lit : predicted);
        items_sent++;
        if (kind == KIND_PUSH && !predicted.push_ok) refused_pushes++;
        if (predicted.tx_valid) tx_bytes++;
        if (predicted.irq_line) irq_high++;
    endtask

    task automatic wait_quiet(input int tail);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic write_irq_enable(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        irq_en = v;
        cfg_writes++;
    endtask

    task automatic random_phase(input int n_items);
        int          done, pick, len, k;
        logic [1:0]  kind;
        logic [31:0] wd;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(0, 99);
            wd = $urandom;
            if (pick < 12) begin
                // burst of received bytes, often enough to fill the ring
                len = $urandom_range(1, 20);
                repeat (len) offer_item(KIND_PUSH, 4'($urandom_range(0, 15)), $urandom,
                                        8'($urandom_range(0, 255)), 1'b0, '0);
                done += len;
            end else if (pick < 22) begin
                len = $urandom_range(1, 18);
                repeat (len) offer_item(KIND_READ, REG_RX, $urandom,
                                        8'($urandom_range(0, 255)), 1'b0, '0);
                done += len;
            end else if (pick < 27) begin
                wd[CTL_RX_INT_EN_BIT] = ($urandom_range(0, 3) != 0);
                offer_item(KIND_WRITE, REG_CTL, wd, 8'($urandom_range(0, 255)), 1'b0, '0);
                done++;
            end else if (pick < 32) begin
                offer_item(KIND_WRITE, REG_STATUS, wd, 8'($urandom_range(0, 255)), 1'b0, '0);
                done++;
            end else begin
                k = $urandom_range(0, 99);
                kind = (k < 40) ? KIND_READ : (k < 65) ? KIND_WRITE :
                       (k < 96) ? KIND_PUSH : KIND_SPARE;
                k = $urandom_range(0, 7);
                if (k == 0) wd = ALL_ONES;
                else if (k == 1) wd = '0;
                offer_item(kind, 4'($urandom_range(0, 15)), wd,
                           8'($urandom_range(0, 255)), 1'b0, '0);
                done++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want_v, got_v);
            err_count++;
        end
    endtask

    // result side: checks every item against the oldest expectation and drives m_tready
    initial begin
        uart_res_t got, want;
        int        hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.read_data = m_tdata[31:0];
                got.push_ok   = m_tdata[32];
                got.rx_free   = m_tdata[37:33];
                got.irq_line  = m_tdata[38];
                got.tx_valid  = m_tdata[39];
                got.tx_byte   = m_tdata[47:40];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, m_tdata);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("push_accepted", 32'(want.push_ok), 32'(got.push_ok));
                    check_field("rx_free", 32'(want.rx_free), 32'(got.rx_free));
                    check_field("irq_line", 32'(want.irq_line), 32'(got.irq_line));
                    check_field("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
                    check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
                    results_checked++;
                end
            end
            if (sink_hold_req > 0) begin
                hold_left = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= !jitter_on || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("uart_rx_fifo_register_block_top verification failed");
        $finish;
    end

    initial begin
        int i, k;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        ring_head = '0;
        ring_count = '0;
        line_ctl = '0;
        uart_ctl = '0;
        fifo_ctl = '0;
        modem_ctl = '0;
        baud_div = '0;
        rx_latch = 1'b0;
        irq_en = 1'b1;
        jitter_on = 1'b1;
        sink_hold_req = 0;

        // kind, reg, write data, rx byte, repeats, typed-in, result
        dir_rows.push_back('{KIND_READ, REG_STATUS, ALL_ONES, 8'hFF, 1, 1'b1,
                             '{32'h6, 1'b0, 5'd16, 1'b0, 1'b0, 8'h0}});
        dir_rows.push_back('{KIND_READ, REG_FIFO_STAT, 32'h0, 8'h0, 1, 1'b1,
                             '{32'h0, 1'b0, 5'd16, 1'b0, 1'b0, 8'h0}});
        dir_rows.push_back('{KIND_READ, REG_RX, 32'h0, 8'h0, 1, 1'b1,
                             '{32'h0, 1'b0, 5'd16, 1'b0, 1'b0, 8'h0}});
        dir_rows.push_back('{KIND_READ, REG_UNMAPPED, ALL_ONES, 8'h0, 1, 1'b1,
                             '{32'h0, 1'b0, 5'd16, 1'b0, 1'b0, 8'h0}});
        dir_rows.push_back('{KIND_WRITE, REG_UNMAPPED, ALL_ONES, 8'hFF, 1, 1'b1,
                             '{32'h0, 1'b0, 5'd16, 1'b0, 1'b0, 8'h0}});
        dir_rows.push_back('{KIND_SPARE, REG_TX, ALL_ONES, 8'hFF, 1, 1'b1,
                             '{32'h0, 1'b0, 5'd16, 1'b0, 1'b0, 8'h0}});
        dir_rows.push_back('{KIND_WRITE, REG_TX, ALL_ONES, 8'h0, 1, 1'b1,
                             '{32'h0, 1'b0, 5'd16, 1'b0, 1'b1, 8'hFF}});
        dir_rows.push_back('{KIND_WRITE, REG_TX, 32'h0, 8'h0, 1, 1'b1,
                             '{32'h0, 1'b0, 5'd16, 1'b0, 1'b1, 8'h0}});
        dir_rows.push_back('{KIND_WRITE, REG_CTL, ALL_ONES, 8'h0, 1, 1'b0, '0});
        dir_rows.push_back('{KIND_READ, REG_CTL, 32'h0, 8'h0, 1, 1'b0, '0});
        // fill the ring: bytes 0x00, 0x11 .. 0xFF, then one refused
        dir_rows.push_back('{KIND_PUSH, REG_LINE_CTL, 32'h0, 8'h00, RING_DEPTH, 1'b0, '0});
        dir_rows.push_back('{KIND_PUSH, REG_RX, ALL_ONES, 8'hA5, 1, 1'b0, '0});
        dir_rows.push_back('{KIND_READ, REG_FIFO_STAT, 32'h0, 8'h0, 1, 1'b1,
                             '{32'h100, 1'b0, 5'd0, 1'b1, 1'b0, 8'h0}});
        dir_rows.push_back('{KIND_READ, REG_STATUS, 32'h0, 8'h0, 2, 1'b0, '0});
        dir_rows.push_back('{KIND_WRITE, REG_STATUS, 32'hFFFF_FFEF, 8'h0, 1, 1'b0, '0});
        dir_rows.push_back('{KIND_READ, REG_STATUS, 32'h0, 8'h0, 1, 1'b0, '0});
        dir_rows.push_back('{KIND_WRITE, REG_STATUS, 32'h10, 8'h0, 1, 1'b0, '0});
        dir_rows.push_back('{KIND_READ, REG_RX, 32'h0, 8'h0, 2, 1'b0, '0});
        dir_rows.push_back('{KIND_WRITE, REG_ERR, ALL_ONES, 8'h0, 1, 1'b0, '0});
        dir_rows.push_back('{KIND_WRITE, REG_FIFO_STAT, ALL_ONES, 8'h0, 1, 1'b0, '0});
        dir_rows.push_back('{KIND_WRITE, REG_MODEM_STAT, ALL_ONES, 8'h0, 1, 1'b0, '0});
        dir_rows.push_back('{KIND_WRITE, REG_RX, ALL_ONES, 8'h0, 1, 1'b0, '0});
        dir_rows.push_back('{KIND_WRITE, REG_BAUD, ALL_ONES, 8'h0, 1, 1'b0, '0});
        dir_rows.push_back('{KIND_READ, REG_BAUD, 32'h0, 8'h0, 1, 1'b0, '0});
        dir_rows.push_back('{KIND_READ, REG_MODEM_STAT, 32'h0, 8'h0, 1, 1'b0, '0});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < dir_rows.size(); i++) begin
            for (k = 0; k < dir_rows[i].reps; k++) begin
                offer_item(dir_rows[i].kind, dir_rows[i].sel, dir_rows[i].wdata,
                           dir_rows[i].rbyte + 8'(k * 17), dir_rows[i].fixed, dir_rows[i].res);
            end
        end
        directed_items = items_sent;

        wait_quiet(4);
        write_irq_enable(1'b0);
        random_phase(200);

        // steady stretch, neither side idles
        wait_quiet(4);
        write_irq_enable(1'b1);
        jitter_on = 1'b0;
        random_phase(200);

        // long receiver hold-off while items keep coming, then a full drain mid-phase
        wait_quiet(4);
        write_irq_enable(1'b0);
        jitter_on = 1'b1;
        sink_hold_req = 60;
        random_phase(100);
        wait_quiet(1);
        random_phase(100);

        wait_quiet(4);
        write_irq_enable(1'b1);
        sink_hold_req = 80;
        random_phase(200);

        wait_quiet(12);
        $display("Ran %0d items (%0d directed) over %0d interrupt-enable settings; %0d results checked.",
                 items_sent, directed_items, cfg_writes, results_checked);
        $display("Saw %0d refused pushes, %0d transmit bytes, %0d interrupt-high results, %0d input stalls.",
                 refused_pushes, tx_bytes, irq_high, input_stalls);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("uart_rx_fifo_register_block_top verification clean");
        end else begin
            $display("uart_rx_fifo_register_block_top verification failed");
        end
        $finish;
    end

endmodule
